[rtl/pcsba_pkg.sv]
// ----------------------------------------------------------------------------
// pcsba_pkg
// Shared types and constants of the per-channel slot bitmap allocator.
// ----------------------------------------------------------------------------
package pcsba_pkg;

    localparam int DEF_NUM_CHANNELS      = 8;
    localparam int DEF_SLOTS_PER_CHANNEL = 64;

    localparam int CHANNEL_W = 3;
    localparam int SLOT_W    = 6;

    typedef enum logic [0:0] {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } opcode_t;

    typedef struct packed {
        opcode_t              opcode;
        logic [CHANNEL_W-1:0] channel;
        logic [SLOT_W-1:0]    slot_index;
    } req_t;

    typedef struct packed {
        logic [SLOT_W-1:0] granted_slot;
        logic              grant_ok;
        logic              channel_full;
    } rsp_t;

endpackage

[rtl/pcsba_stream_if.sv]
// ----------------------------------------------------------------------------
// pcsba_stream_if
// Valid/ready channel that carries one item per handshake.
// ----------------------------------------------------------------------------
interface pcsba_stream_if #(
    parameter type payload_t = logic
);

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );

endinterface

[rtl/pcsba_first_free.sv]
// ----------------------------------------------------------------------------
// pcsba_first_free
// Finds the lowest clear bit of a slot map and returns it as a one-hot mask
// and as a binary index.
// ----------------------------------------------------------------------------
module pcsba_first_free #(
    parameter int SLOTS = pcsba_pkg::DEF_SLOTS_PER_CHANNEL,
    localparam int IDX_W = $clog2(SLOTS)
) (
    input  logic [SLOTS-1:0] used_map,
    output logic             found,
    output logic [SLOTS-1:0] free_onehot,
    output logic [IDX_W-1:0] free_index
);

    logic [SLOTS-1:0] free_map;

    assign free_map    = ~used_map;
    assign found       = |free_map;
    assign free_onehot = free_map & (~free_map + SLOTS'(1));

    always_comb
    begin
        free_index = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (free_onehot[i])
            begin
                free_index = free_index | IDX_W'(i);
            end
        end
    end

endmodule

[rtl/per_channel_slot_bitmap_allocator_unit.sv]
// ----------------------------------------------------------------------------
// per_channel_slot_bitmap_allocator_unit
// Keeps one slot-usage bitmap per channel; allocates the lowest free slot or
// releases a named slot, and reports whether the channel is full.
// ----------------------------------------------------------------------------
// A request item is held in the input register and its result in the result
// register. Throughput: one item per cycle while results are taken; the map
// read-modify-write and first-free search are combinational between them.
// Reset: asynchronous and active low; every channel's map is cleared, so all
// slots are free, and both pipeline registers are emptied.
// ----------------------------------------------------------------------------
module per_channel_slot_bitmap_allocator_unit #(
    parameter int NUM_CHANNELS      = pcsba_pkg::DEF_NUM_CHANNELS,
    parameter int SLOTS_PER_CHANNEL = pcsba_pkg::DEF_SLOTS_PER_CHANNEL
) (
    input  logic                  clk,
    input  logic                  rst_n,
    pcsba_stream_if.sink          req,
    pcsba_stream_if.source        rsp
);

    localparam int CH_IDX_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CH_EXT_W   = (CH_IDX_W > pcsba_pkg::CHANNEL_W) ? CH_IDX_W
                                                                  : pcsba_pkg::CHANNEL_W;
    localparam int SLOT_IDX_W = $clog2(SLOTS_PER_CHANNEL);
    localparam int SLOT_EXT_W = (SLOT_IDX_W > pcsba_pkg::SLOT_W) ? SLOT_IDX_W
                                                                 : pcsba_pkg::SLOT_W;

    logic [SLOTS_PER_CHANNEL-1:0] map_reg [NUM_CHANNELS];

    pcsba_pkg::req_t req_reg;
    logic            req_valid_reg;
    pcsba_pkg::rsp_t rsp_reg;
    pcsba_pkg::rsp_t rsp_next;
    logic            rsp_valid_reg;

    logic                         advance;
    logic [CH_EXT_W-1:0]          ch_ext;
    logic                         ch_ok;
    logic [CH_IDX_W-1:0]          ch_idx;
    logic [SLOT_EXT_W-1:0]        slot_ext;
    logic                         slot_ok;
    logic [SLOTS_PER_CHANNEL-1:0] cur_map;
    logic [SLOTS_PER_CHANNEL-1:0] map_next;
    logic                         found;
    logic [SLOTS_PER_CHANNEL-1:0] free_onehot;
    logic [SLOT_IDX_W-1:0]        free_index;
    logic [SLOT_EXT_W-1:0]        free_index_ext;
    logic                         is_alloc;
    logic                         map_we;

    assign advance   = req_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign req.ready = !req_valid_reg || advance;

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_reg;

    assign ch_ext   = CH_EXT_W'(req_reg.channel);
    assign ch_ok    = ch_ext < NUM_CHANNELS;
    assign ch_idx   = ch_ext[CH_IDX_W-1:0];
    assign slot_ext = SLOT_EXT_W'(req_reg.slot_index);
    assign slot_ok  = slot_ext < SLOTS_PER_CHANNEL;
    assign cur_map  = ch_ok ? map_reg[ch_idx] : '0;
    assign is_alloc = (req_reg.opcode == pcsba_pkg::OP_ALLOC);
    assign map_we   = advance && ch_ok;

    pcsba_first_free #(
        .SLOTS (SLOTS_PER_CHANNEL)
    ) u_first_free (
        .used_map    (cur_map),
        .found       (found),
        .free_onehot (free_onehot),
        .free_index  (free_index)
    );

    assign free_index_ext = SLOT_EXT_W'(free_index);

    always_comb
    begin
        map_next = cur_map;
        rsp_next = '0;
        if (is_alloc)
        begin
            if (found)
            begin
                map_next              = cur_map | free_onehot;
                rsp_next.grant_ok     = 1'b1;
                rsp_next.granted_slot = free_index_ext[pcsba_pkg::SLOT_W-1:0];
            end
        end
        else if (slot_ok)
        begin
            map_next = cur_map & ~(SLOTS_PER_CHANNEL'(1) << slot_ext);
        end
        if (!ch_ok)
        begin
            rsp_next = '0;
        end
        else
        begin
            rsp_next.channel_full = &map_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
            for (int c = 0; c < NUM_CHANNELS; c++)
            begin
                map_reg[c] <= '0;
            end
        end
        else
        begin
            if (req.ready)
            begin
                req_valid_reg <= req.valid;
            end
            if (advance)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (map_we)
            begin
                map_reg[ch_idx] <= map_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            req_reg <= req.payload;
        end
        if (advance)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule

[rtl/pcsba_checker.sv]
// ----------------------------------------------------------------------------
// pcsba_checker
// Port-level checks of the slot allocator, bound to the top level.
// ----------------------------------------------------------------------------
module pcsba_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            req_valid,
    input logic            req_ready,
    input logic            rsp_valid,
    input logic            rsp_ready,
    input pcsba_pkg::rsp_t rsp_payload
);

    // A failed allocate and a free both report slot zero.
    a_no_grant_zero_slot: assert property (
        @(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_payload.grant_ok) |-> (rsp_payload.granted_slot == '0)
    ) else $error("granted_slot is nonzero without a grant");

    // With the result register empty, the input side never stalls.
    a_ready_when_empty: assert property (
        @(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> req_ready
    ) else $error("request stalled while no result is pending");

    // An item taken while no result is pending is followed by a valid result.
    a_result_follows: assert property (
        @(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && !rsp_valid) |-> ##2 rsp_valid
    ) else $error("accepted item produced no result");

    a_stalled_result_holds: assert property (
        @(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_payload))
    ) else $error("stalled result changed");

endmodule

bind per_channel_slot_bitmap_allocator_unit pcsba_checker u_pcsba_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_payload (rsp.payload)
);

[verif/tb_per_channel_slot_bitmap_allocator_unit.sv]
// ----------------------------------------------------------------------------
// tb_per_channel_slot_bitmap_allocator_unit
// Drives allocate and free requests into the slot allocator, keeps its own copy
// of every channel's slot map to predict each grant and full flag, and checks
// each result against the oldest prediction with random gaps on both sides.
// ----------------------------------------------------------------------------
module tb_per_channel_slot_bitmap_allocator_unit;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_CH      = pcsba_pkg::DEF_NUM_CHANNELS;
    localparam int SLOTS       = pcsba_pkg::DEF_SLOTS_PER_CHANNEL;
    localparam int CH_W        = pcsba_pkg::CHANNEL_W;
    localparam int SL_W        = pcsba_pkg::SLOT_W;
    localparam int RANDOM_REQS = 600;
    localparam int FILL_LEN    = SLOTS + 4;

    class slot_map_scoreboard;
        logic [SLOTS-1:0] used_map [NUM_CH];
        pcsba_pkg::rsp_t  grant_fifo [$];
        int               mismatch_count;

        function new();
            foreach (used_map[c])
            begin
                used_map[c] = '0;
            end
            mismatch_count = 0;
        endfunction

        function void note_request(pcsba_pkg::req_t item);
            pcsba_pkg::rsp_t  exp;
            logic [SLOTS-1:0] word;
            bit               found;
            exp   = '0;
            found = 1'b0;
            word  = used_map[item.channel];
            if (item.opcode == pcsba_pkg::OP_ALLOC)
            begin
                for (int s = 0; s < SLOTS; s++)
                begin
                    if (!found && !word[s])
                    begin
                        found            = 1'b1;
                        word[s]          = 1'b1;
                        exp.granted_slot = SL_W'(s);
                        exp.grant_ok     = 1'b1;
                    end
                end
            end
            else
            begin
                word[item.slot_index] = 1'b0;
            end
            used_map[item.channel] = word;
            exp.channel_full       = &word;
            grant_fifo.push_back(exp);
        endfunction

        function void check_response(pcsba_pkg::rsp_t got);
            pcsba_pkg::rsp_t exp;
            if (grant_fifo.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: slot=%0d ok=%0b full=%0b",
                             got.granted_slot, got.grant_ok, got.channel_full);
                return;
            end
            exp = grant_fifo.pop_front();
            if (got.granted_slot !== exp.granted_slot || got.grant_ok !== exp.grant_ok ||
                got.channel_full !== exp.channel_full)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("expected slot=%0d ok=%0b full=%0b, got slot=%0d ok=%0b full=%0b",
                             exp.granted_slot, exp.grant_ok, exp.channel_full,
                             got.granted_slot, got.grant_ok, got.channel_full);
            end
        endfunction

        function int pending();
            return grant_fifo.size();
        endfunction

        function bit failed();
            return (mismatch_count != 0) || (grant_fifo.size() != 0);
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   sent_count;
    int   tx_calm;
    int   rx_calm;

    slot_map_scoreboard slot_sb = new();

    pcsba_stream_if #(.payload_t(pcsba_pkg::req_t)) req_if ();
    pcsba_stream_if #(.payload_t(pcsba_pkg::rsp_t)) rsp_if ();

    per_channel_slot_bitmap_allocator_unit u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400us;
        $display("RESULT: ERROR");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && req_if.valid && req_if.ready)
            slot_sb.note_request(req_if.payload);
        if (rst_n && rsp_if.valid && rsp_if.ready)
            slot_sb.check_response(rsp_if.payload);
    end

    task automatic send_request(input pcsba_pkg::opcode_t op,
                                input logic [CH_W-1:0] ch,
                                input logic [SL_W-1:0] slot);
        pcsba_pkg::req_t item;
        int              gap;
        item.opcode     = op;
        item.channel    = ch;
        item.slot_index = slot;
        if (tx_calm > 0)
        begin
            gap = 0;
            tx_calm--;
        end
        else
        begin
            gap = $urandom_range(0, 5);
            if ($urandom_range(0, 15) == 0)
                tx_calm = $urandom_range(10, 40);
        end
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid   <= 1'b1;
        req_if.payload <= item;
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);
        sent_count++;
    endtask

    task automatic wait_for_drain();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (slot_sb.pending() != 0) @(posedge clk);
    endtask

    initial
    begin
        rsp_if.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            int stall;
            if (rx_calm > 0)
            begin
                stall = 0;
                rx_calm--;
            end
            else
            begin
                stall = $urandom_range(0, 5);
                if ($urandom_range(0, 15) == 0)
                    rx_calm = $urandom_range(10, 40);
            end
            if (stall > 0)
            begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_if.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_if.valid) @(posedge clk);
        end
    end

    initial
    begin
        logic [CH_W-1:0] hot_ch;
        logic [CH_W-1:0] ch;
        logic [SL_W-1:0] slot;
        int              burst_len;
        int              alloc_pct;
        bit              first_burst;

        sent_count     = 0;
        tx_calm        = 0;
        rx_calm        = 0;
        first_burst    = 1'b1;
        hot_ch         = '0;
        rst_n          <= 1'b0;
        req_if.valid   <= 1'b0;
        req_if.payload <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Lowest-free search, reuse of a released slot, and freeing free slots.
        send_request(pcsba_pkg::OP_ALLOC, 3'd0, 6'd63);
        send_request(pcsba_pkg::OP_ALLOC, 3'd0, 6'd0);
        send_request(pcsba_pkg::OP_ALLOC, 3'd0, 6'd21);
        send_request(pcsba_pkg::OP_FREE,  3'd0, 6'd1);
        send_request(pcsba_pkg::OP_ALLOC, 3'd0, 6'd42);
        send_request(pcsba_pkg::OP_FREE,  3'd0, 6'd63);
        send_request(pcsba_pkg::OP_FREE,  3'd0, 6'd0);
        send_request(pcsba_pkg::OP_FREE,  3'd0, 6'd0);
        send_request(pcsba_pkg::OP_ALLOC, 3'd0, 6'd0);
        send_request(pcsba_pkg::OP_ALLOC, 3'd7, 6'd63);
        send_request(pcsba_pkg::OP_ALLOC, 3'd7, 6'd0);
        send_request(pcsba_pkg::OP_FREE,  3'd7, 6'd0);
        send_request(pcsba_pkg::OP_FREE,  3'd7, 6'd63);
        send_request(pcsba_pkg::OP_ALLOC, 3'd7, 6'd0);
        send_request(pcsba_pkg::OP_FREE,  3'd5, 6'd42);
        send_request(pcsba_pkg::OP_ALLOC, 3'd2, 6'd21);
        wait_for_drain();

        // Fill bursts drive channels to full and past it; mixed bursts churn them.
        sent_count = 0;
        while (sent_count < RANDOM_REQS)
        begin
            if (first_burst || $urandom_range(0, 9) < 3)
            begin
                hot_ch = CH_W'($urandom_range(0, NUM_CH - 1));
                repeat (FILL_LEN)
                    send_request(pcsba_pkg::OP_ALLOC, hot_ch,
                                 SL_W'($urandom_range(0, SLOTS - 1)));
                first_burst = 1'b0;
            end
            else
            begin
                burst_len = $urandom_range(8, 24);
                alloc_pct = $urandom_range(20, 80);
                repeat (burst_len)
                begin
                    if ($urandom_range(0, 1) == 0)
                        ch = hot_ch;
                    else
                        ch = CH_W'($urandom_range(0, NUM_CH - 1));
                    if ($urandom_range(0, 1) == 0)
                        slot = SL_W'($urandom_range(0, SLOTS - 1));
                    else
                        slot = SL_W'($urandom_range(0, 15));
                    if ($urandom_range(0, 99) < alloc_pct)
                        send_request(pcsba_pkg::OP_ALLOC, ch, slot);
                    else
                        send_request(pcsba_pkg::OP_FREE, ch, slot);
                end
            end
            if ($urandom_range(0, 7) == 0)
                wait_for_drain();
        end

        wait_for_drain();
        repeat (8) @(posedge clk);
        if (slot_sb.failed())
            $display("RESULT: ERROR");
        else
            $display("RESULT: OK");
        $finish;
    end

endmodule
